// ----- hdl/ief_pkg.sv -----
// Shared types and constants for the inverse error function pipeline.
// Used by ief_log, ief_sqrt, ief_poly and inverse_error_function.
`timescale 1ns / 1ps

package ief_pkg;

    localparam int ARG_FRAC_BITS_DEF    = 23;
    localparam int RESULT_FRAC_BITS_DEF = 20;

    // The values passed between the blocks are Q30
    localparam int Q_BITS   = 30;
    localparam int W_W      = 34;   // -ln(1-x^2), Q30, below 12.0
    localparam int S_W      = 32;   // sqrt(w), Q30
    localparam int P_W      = 35;   // polynomial value and argument, signed Q30
    localparam int E_W      = 5;    // integer part of -log2(u)
    localparam int NUM_SQ   = 30;   // squaring rounds of the log
    localparam int NUM_ROOT = 32;   // digit steps of the root
    localparam int NUM_COEF = 9;

    localparam logic [Q_BITS-1:0] CLAMP_Q30 = 30'd1073731087;
    localparam logic [Q_BITS-1:0] LN2_Q30   = 30'd744261118;

    localparam logic [W_W-1:0]        W_SPLIT    = 34'd5368709120;  // 5.0
    localparam logic signed [P_W-1:0] T_LOW_OFS  = 35'sd2684354560; // 2.5
    localparam logic signed [P_W-1:0] T_HIGH_OFS = 35'sd3221225472; // 3.0

    localparam logic signed [P_W-1:0] LOW_COEF [0:NUM_COEF-1] = '{
        35'sd30, 35'sd369, -35'sd3783, -35'sd4715, 35'sd234699, -35'sd1346177,
        -35'sd4485752, 35'sd264828464, 35'sd1612126078
    };

    localparam logic signed [P_W-1:0] HIGH_COEF [0:NUM_COEF-1] = '{
        -35'sd214978, 35'sd108395, 35'sd1448846, -35'sd3944314, 35'sd6162750,
        -35'sd8184555, 35'sd10134910, 35'sd1075539332, 35'sd3041885698
    };

    // Control and side data that travel with every item
    typedef struct packed {
        logic              valid;
        logic              xneg;
        logic [Q_BITS-1:0] a;
    } side_t;

endpackage

// ----- hdl/inverse_error_function.sv -----
// Inverse error function, streaming pipeline: erfinv(x) for a Q1.ARG_FRAC_BITS
// argument. Depends on ief_pkg, ief_log, ief_sqrt and ief_poly.
//
// Usage:
//   Input channel s_*: one argument x per transaction in s_tdata, signed
//   two's complement with ARG_FRAC_BITS fraction bits; |x| is clamped to
//   0.99999, any bit pattern is legal.
//   Output channel m_*: one result per argument, in order, in m_tdata,
//   signed with RESULT_FRAC_BITS fraction bits.
//   Pipeline: 5 front-end stages, 30 squaring stages of the log, 3 stages
//   of ln2 scaling, 32 root stages, 17 Horner stages and 2 output stages.
//   Throughput: one transaction per cycle while the output is not stalled;
//   each stage holds its own item.
//   Back-pressure: the pipeline advances only while the output register is
//   empty or being read. With m_tready low and a result waiting, every stage
//   holds and s_tready is low; nothing is dropped or repeated.
//   Reset: aresetn low clears all valid bits and holds s_tready low; the
//   pipeline is empty after.
`timescale 1ns / 1ps

module inverse_error_function #(
    parameter int ARG_FRAC_BITS    = ief_pkg::ARG_FRAC_BITS_DEF,
    parameter int RESULT_FRAC_BITS = ief_pkg::RESULT_FRAC_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // [ARG_FRAC_BITS+1:0] arg_value, rest zero
    input  logic [((ARG_FRAC_BITS + 9) / 8) * 8 - 1:0]   s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // [RESULT_FRAC_BITS+2:0] inv_erf_value, rest zero
    output logic [((RESULT_FRAC_BITS + 10) / 8) * 8 - 1:0] m_tdata
);

    localparam int AW     = ARG_FRAC_BITS + 2;
    localparam int OW     = RESULT_FRAC_BITS + 3;
    localparam int OUT_TW = ((RESULT_FRAC_BITS + 10) / 8) * 8;
    localparam int PW     = ief_pkg::P_W;
    localparam int QB     = ief_pkg::Q_BITS;
    localparam int SH     = 2 * QB - RESULT_FRAC_BITS;
    localparam int PRW    = PW + QB;
    localparam logic [OW-2:0] LIM     = '1;
    localparam logic [OW-1:0] OUT_MIN = OW'(1) << (OW - 1);

    logic                          en;
    logic                          out_valid_reg;
    logic [OW-1:0]                 out_data_reg;

    ief_pkg::side_t                log_side, root_side, poly_side;
    logic [ief_pkg::W_W-1:0]       log_w, root_w;
    logic [ief_pkg::S_W-1:0]       root_s;
    logic signed [PW-1:0]          poly_p;

    // advance whenever the output register is free or being drained
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en && aresetn;

    ief_log #(
        .ARG_FRAC_BITS(ARG_FRAC_BITS)
    ) u_log (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .arg_value ($signed(s_tdata[AW-1:0])),
        .side_out  (log_side),
        .w_out     (log_w)
    );

    ief_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .side_in  (log_side),
        .w_in     (log_w),
        .side_out (root_side),
        .w_out    (root_w),
        .s_out    (root_s)
    );

    ief_poly u_poly (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .side_in  (root_side),
        .w_in     (root_w),
        .s_in     (root_s),
        .side_out (poly_side),
        .p_out    (poly_p)
    );

    // scale by |x|, then round, saturate and sign
    logic [PW-1:0]   p_mag;
    logic [PRW-1:0]  fprod_reg;
    logic            fneg_reg, fvalid_reg;
    logic [PRW:0]    rnd;
    logic [PRW:0]    r_full;
    logic [OW-2:0]   r_sat;
    logic [OW-1:0]   out_next;

    assign p_mag = poly_p[PW-1] ? PW'(-poly_p) : PW'(poly_p);

    always_comb begin
        rnd      = {1'b0, fprod_reg} + ((PRW + 1)'(1) << (SH - 1));
        r_full   = rnd >> SH;
        r_sat    = (r_full > (PRW + 1)'(LIM)) ? LIM : r_full[OW-2:0];
        out_next = fneg_reg ? OW'(-{1'b0, r_sat}) : {1'b0, r_sat};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            fvalid_reg    <= poly_side.valid;
            out_valid_reg <= fvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fprod_reg    <= p_mag * poly_side.a;
            fneg_reg     <= poly_side.xneg ^ poly_p[PW-1];
            out_data_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TW'(out_data_reg);

    // a held result blocks new transactions
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while output stalled");

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // saturation keeps the magnitude below the most negative code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OW-1:0] != OUT_MIN))
        else $error("result magnitude out of range");

endmodule

// ----- hdl/ief_log.sv -----
// Front end: clamp |x|, form u = 1 - x^2 and w = -ln(u) in Q30.
// Depends on ief_pkg.
`timescale 1ns / 1ps

module ief_log #(
    parameter int ARG_FRAC_BITS = ief_pkg::ARG_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [ARG_FRAC_BITS+1:0] arg_value,
    output ief_pkg::side_t                side_out,
    output logic [ief_pkg::W_W-1:0]       w_out
);

    localparam int AW      = ARG_FRAC_BITS + 2;
    localparam int A_SHIFT = 30 - ARG_FRAC_BITS;
    localparam int QB      = ief_pkg::Q_BITS;
    localparam int NSQ     = ief_pkg::NUM_SQ;
    localparam int EW      = ief_pkg::E_W;

    // stage 1: magnitude and clamp
    logic [AW-1:0]        mag;
    logic [31:0]          a_wide;
    ief_pkg::side_t       s1_next, s1_reg;

    always_comb begin
        mag            = arg_value[AW-1] ? AW'(-arg_value) : AW'(arg_value);
        a_wide         = 32'(mag) << A_SHIFT;
        s1_next.valid  = in_valid;
        s1_next.xneg   = arg_value[AW-1];
        s1_next.a      = (a_wide > 32'(ief_pkg::CLAMP_Q30)) ? ief_pkg::CLAMP_Q30
                                                           : a_wide[QB-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg <= '0;
        end else if (en) begin
            s1_reg <= s1_next;
        end
    end

    // stage 2: u = 2^60 - a*a
    logic [59:0]    a_sq;
    logic [63:0]    u_next, u_reg;
    ief_pkg::side_t s2_reg;

    assign a_sq   = s1_reg.a * s1_reg.a;
    assign u_next = (64'd1 << 60) - {4'd0, a_sq};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_reg <= '0;
        end else if (en) begin
            s2_reg <= s1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg <= u_next;
        end
    end

    // stages 3..5: normalize, two shift steps per stage
    logic [63:0]    n3_next, n3_reg, n4_next, n4_reg, n5_next, n5_reg;
    logic [63:0]    n3_mid, n4_mid, n5_mid;
    logic [5:0]     lz3_next, lz3_reg, lz4_next, lz4_reg, lz5_next, lz5_reg;
    ief_pkg::side_t s3_reg, s4_reg, s5_reg;

    always_comb begin
        lz3_next    = '0;
        lz3_next[5] = (u_reg[63:32] == '0);
        n3_mid      = lz3_next[5] ? (u_reg << 32) : u_reg;
        lz3_next[4] = (n3_mid[63:48] == '0);
        n3_next     = lz3_next[4] ? (n3_mid << 16) : n3_mid;

        lz4_next    = lz3_reg;
        lz4_next[3] = (n3_reg[63:56] == '0);
        n4_mid      = lz4_next[3] ? (n3_reg << 8) : n3_reg;
        lz4_next[2] = (n4_mid[63:60] == '0);
        n4_next     = lz4_next[2] ? (n4_mid << 4) : n4_mid;

        lz5_next    = lz4_reg;
        lz5_next[1] = (n4_reg[63:62] == '0);
        n5_mid      = lz5_next[1] ? (n4_reg << 2) : n4_reg;
        lz5_next[0] = ~n5_mid[63];
        n5_next     = lz5_next[0] ? (n5_mid << 1) : n5_mid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_reg <= '0;
            s4_reg <= '0;
            s5_reg <= '0;
        end else if (en) begin
            s3_reg <= s2_reg;
            s4_reg <= s3_reg;
            s5_reg <= s4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n3_reg  <= n3_next;
            lz3_reg <= lz3_next;
            n4_reg  <= n4_next;
            lz4_reg <= lz4_next;
            n5_reg  <= n5_next;
            lz5_reg <= lz5_next;
        end
    end

    // stages 6..35: one squaring round each, one fraction bit of log2(m)
    logic [QB:0]    m_sq_reg [1:NSQ];
    logic [QB-1:0]  f_sq_reg [1:NSQ];
    logic [EW-1:0]  e_sq_reg [1:NSQ];
    ief_pkg::side_t side_sq_reg [1:NSQ];

    for (genvar i = 1; i <= NSQ; i++) begin : g_sq
        logic [QB:0]    m_prev;
        logic [QB-1:0]  f_prev;
        logic [EW-1:0]  e_prev;
        ief_pkg::side_t side_prev;
        logic [2*QB+1:0] sq;
        logic [QB+1:0]  q;
        logic [QB:0]    m_next;
        logic [QB-1:0]  f_next;

        if (i == 1) begin : g_first
            assign m_prev    = n5_reg[63:63-QB];
            assign f_prev    = '0;
            assign e_prev    = EW'(lz5_reg - 6'd3);
            assign side_prev = s5_reg;
        end else begin : g_rest
            assign m_prev    = m_sq_reg[i-1];
            assign f_prev    = f_sq_reg[i-1];
            assign e_prev    = e_sq_reg[i-1];
            assign side_prev = side_sq_reg[i-1];
        end

        always_comb begin
            sq     = m_prev * m_prev;
            q      = sq[2*QB+1:QB];
            // a square of 2.0 or more yields a one bit; halve back into [1,2)
            m_next = q[QB+1] ? q[QB+1:1] : q[QB:0];
            f_next = {f_prev[QB-2:0], q[QB+1]};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_sq_reg[i] <= '0;
            end else if (en) begin
                side_sq_reg[i] <= side_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                m_sq_reg[i] <= m_next;
                f_sq_reg[i] <= f_next;
                e_sq_reg[i] <= e_prev;
            end
        end
    end

    // -log2(u) in Q30, then scale by ln2 in two partial products
    logic [EW+QB-1:0] lg_next, lg_reg;
    logic [47:0]      plo_next, plo_reg;
    logic [46:0]      phi_next, phi_reg;
    logic [65:0]      wsum;
    ief_pkg::side_t   lg_side_reg, pp_side_reg, w_side_reg;
    logic [ief_pkg::W_W-1:0] w_reg;

    assign lg_next  = {e_sq_reg[NSQ], {QB{1'b0}}} - {{EW{1'b0}}, f_sq_reg[NSQ]};
    assign plo_next = lg_reg[17:0] * ief_pkg::LN2_Q30;
    assign phi_next = lg_reg[EW+QB-1:18] * ief_pkg::LN2_Q30;
    assign wsum     = {phi_reg, 18'd0} + {18'd0, plo_reg} + (66'd1 << (QB - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lg_side_reg <= '0;
            pp_side_reg <= '0;
            w_side_reg  <= '0;
        end else if (en) begin
            lg_side_reg <= side_sq_reg[NSQ];
            pp_side_reg <= lg_side_reg;
            w_side_reg  <= pp_side_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lg_reg  <= lg_next;
            plo_reg <= plo_next;
            phi_reg <= phi_next;
            w_reg   <= wsum[QB+ief_pkg::W_W-1:QB];
        end
    end

    assign side_out = w_side_reg;
    assign w_out    = w_reg;

endmodule

// ----- hdl/ief_sqrt.sv -----
// Pipelined bitwise square root of w * 2^30, one result bit per stage.
// Depends on ief_pkg.
`timescale 1ns / 1ps

module ief_sqrt (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  ief_pkg::side_t          side_in,
    input  logic [ief_pkg::W_W-1:0] w_in,
    output ief_pkg::side_t          side_out,
    output logic [ief_pkg::W_W-1:0] w_out,
    output logic [ief_pkg::S_W-1:0] s_out
);

    localparam int NR = ief_pkg::NUM_ROOT;
    localparam int QB = ief_pkg::Q_BITS;
    localparam int WW = ief_pkg::W_W;

    logic [63:0]    v_reg    [0:NR-1];
    logic [63:0]    res_reg  [0:NR-1];
    logic [WW-1:0]  w_reg    [0:NR-1];
    ief_pkg::side_t side_reg [0:NR-1];

    for (genvar i = 0; i < NR; i++) begin : g_root
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
        logic [63:0]    v_prev, res_prev, trial, v_next, res_next;
        logic [WW-1:0]  w_prev;
        ief_pkg::side_t side_prev;
        logic           ge;

        if (i == 0) begin : g_first
            assign v_prev    = {w_in, {QB{1'b0}}};
            assign res_prev  = '0;
            assign w_prev    = w_in;
            assign side_prev = side_in;
        end else begin : g_rest
            assign v_prev    = v_reg[i-1];
            assign res_prev  = res_reg[i-1];
            assign w_prev    = w_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        always_comb begin
            trial    = res_prev + BIT;
            ge       = (v_prev >= trial);
            v_next   = ge ? (v_prev - trial) : v_prev;
            res_next = ge ? ((res_prev >> 1) + BIT) : (res_prev >> 1);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg[i] <= '0;
            end else if (en) begin
                side_reg[i] <= side_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[i]   <= v_next;
                res_reg[i] <= res_next;
                w_reg[i]   <= w_prev;
            end
        end
    end

    assign side_out = side_reg[NR-1];
    assign w_out    = w_reg[NR-1];
    assign s_out    = res_reg[NR-1][ief_pkg::S_W-1:0];

endmodule

// ----- hdl/ief_poly.sv -----
// Branch select and Horner evaluation of the degree-8 polynomial,
// a multiply stage and a round/add stage per later coefficient. Depends on ief_pkg.
`timescale 1ns / 1ps

module ief_poly (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  ief_pkg::side_t                 side_in,
    input  logic [ief_pkg::W_W-1:0]        w_in,
    input  logic [ief_pkg::S_W-1:0]        s_in,
    output ief_pkg::side_t                 side_out,
    output logic signed [ief_pkg::P_W-1:0] p_out
);

    localparam int PW = ief_pkg::P_W;
    localparam int QB = ief_pkg::Q_BITS;
    localparam int NS = ief_pkg::NUM_COEF - 1;

    // select stage
    logic                 low_next;
    logic signed [PW-1:0] t_next;
    logic                 br0_reg;
    logic signed [PW-1:0] t0_reg, p0_reg;
    ief_pkg::side_t       side0_reg;

    always_comb begin
        low_next = (w_in < ief_pkg::W_SPLIT);
        t_next   = low_next ? ($signed({1'b0, w_in}) - ief_pkg::T_LOW_OFS)
                            : ($signed({3'b000, s_in}) - ief_pkg::T_HIGH_OFS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side0_reg <= '0;
        end else if (en) begin
            side0_reg <= side_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            br0_reg <= low_next;
            t0_reg  <= t_next;
            p0_reg  <= low_next ? ief_pkg::LOW_COEF[0] : ief_pkg::HIGH_COEF[0];
        end
    end

    logic [2*PW-2:0]      prod_reg  [1:NS];
    logic                 neg_reg   [1:NS];
    logic signed [PW-1:0] ta_reg    [1:NS];
    logic                 bra_reg   [1:NS];
    ief_pkg::side_t       sidea_reg [1:NS];
    logic signed [PW-1:0] p_reg     [1:NS];
    logic signed [PW-1:0] tb_reg    [1:NS];
    logic                 brb_reg   [1:NS];
    ief_pkg::side_t       sideb_reg [1:NS];

    for (genvar j = 1; j <= NS; j++) begin : g_step
        logic signed [PW-1:0] p_prev, t_prev, r_signed, p_next;
        logic                 br_prev;
        ief_pkg::side_t       side_prev;
        logic [PW-1:0]        p_mag;
        logic [PW-2:0]        t_mag;
        logic [2*PW-1:0]      rsum;
        logic [PW-1:0]        r_mag;

        if (j == 1) begin : g_first
            assign p_prev    = p0_reg;
            assign t_prev    = t0_reg;
            assign br_prev   = br0_reg;
            assign side_prev = side0_reg;
        end else begin : g_rest
            assign p_prev    = p_reg[j-1];
            assign t_prev    = tb_reg[j-1];
            assign br_prev   = brb_reg[j-1];
            assign side_prev = sideb_reg[j-1];
        end

        always_comb begin
            p_mag    = p_prev[PW-1] ? PW'(-p_prev) : PW'(p_prev);
            t_mag    = t_prev[PW-1] ? (PW-1)'(-t_prev) : (PW-1)'(t_prev);
            // round |p*t| to nearest, ties away from zero, then restore the sign
            rsum     = {1'b0, prod_reg[j]} + (2*PW)'(64'd1 << (QB - 1));
            r_mag    = rsum[QB+PW-1:QB];
            r_signed = neg_reg[j] ? -$signed(r_mag) : $signed(r_mag);
            p_next   = (bra_reg[j] ? ief_pkg::LOW_COEF[j] : ief_pkg::HIGH_COEF[j])
                       + r_signed;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sidea_reg[j] <= '0;
                sideb_reg[j] <= '0;
            end else if (en) begin
                sidea_reg[j] <= side_prev;
                sideb_reg[j] <= sidea_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                prod_reg[j] <= p_mag * t_mag;
                neg_reg[j]  <= p_prev[PW-1] ^ t_prev[PW-1];
                ta_reg[j]   <= t_prev;
                bra_reg[j]  <= br_prev;
                p_reg[j]    <= p_next;
                tb_reg[j]   <= ta_reg[j];
                brb_reg[j]  <= bra_reg[j];
            end
        end
    end

    assign side_out = sideb_reg[NS];
    assign p_out    = p_reg[NS];

endmodule
